### rtl/mrs_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Event kinds, the event record, and status and controller codes.
// ----------------------------------------------------------------------------
package mrs_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_ALL_OFF  = 3'd2,
    KIND_CONTROL  = 3'd3,
    KIND_PROGRAM  = 3'd4
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [6:0]  key;
    logic [6:0]  value;
  } evt_t;

  // Message type as held in bits 6:4 of a channel status byte.
  localparam logic [2:0] TYPE_NOTE_OFF = 3'h0;  // 0x8n
  localparam logic [2:0] TYPE_NOTE_ON  = 3'h1;  // 0x9n
  localparam logic [2:0] TYPE_CONTROL  = 3'h3;  // 0xBn
  localparam logic [2:0] TYPE_PROGRAM  = 3'h4;  // 0xCn
  localparam logic [2:0] TYPE_PRESSURE = 3'h5;  // 0xDn
  localparam logic [2:0] TYPE_SYSTEM   = 3'h7;  // 0xFn

  localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
  localparam logic [6:0] PROGRAM_MASK     = 7'd63;

endpackage

### rtl/mrs_if.sv
// ----------------------------------------------------------------------------
// MIDI running status parser channels
// Valid/ready channels for incoming bytes and outgoing events.
// ----------------------------------------------------------------------------
interface mrs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mrs_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [6:0] event_key;
  logic [6:0] event_value;

  modport source (output valid, output event_kind, output event_key, output event_value,
                  input ready);
  modport sink   (input valid, input event_kind, input event_key, input event_value,
                  output ready);
endinterface

### rtl/mrs_in_stage.sv
// ----------------------------------------------------------------------------
// MIDI running status parser input register
// Holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module mrs_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The register frees up in the same cycle that its beat moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

### rtl/mrs_decode.sv
// ----------------------------------------------------------------------------
// MIDI running status parser decode
// Keeps the running status and decodes completed channel messages.
// ----------------------------------------------------------------------------
module mrs_decode (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_valid_i,
  input  logic [7:0]   byte_i,
  input  logic         take_i,
  output logic         evt_valid_o,
  output mrs_pkg::evt_t evt_o
);

  logic       stat_vld_q, stat_vld_d;
  logic [2:0] stat_type_q, stat_type_d;
  logic       two_q, two_d;
  logic       dcount_q, dcount_d;
  logic [6:0] first_q, first_d;

  logic       adv;
  logic       done;
  logic [6:0] d0, d1;

  assign adv = byte_valid_i && take_i;

  always_comb begin
    stat_vld_d  = stat_vld_q;
    stat_type_d = stat_type_q;
    two_d       = two_q;
    dcount_d    = dcount_q;
    first_d     = first_q;
    done        = 1'b0;
    d0          = byte_i[6:0];
    d1          = '0;

    if (adv) begin
      if (byte_i[7]) begin
        if (byte_i[6:4] == mrs_pkg::TYPE_SYSTEM) begin
          // Real-time bytes pass untouched; system-common bytes drop the status.
          if (!byte_i[3]) begin
            stat_vld_d = 1'b0;
            dcount_d   = 1'b0;
          end
        end else begin
          stat_vld_d  = 1'b1;
          stat_type_d = byte_i[6:4];
          dcount_d    = 1'b0;
          two_d       = !(byte_i[6:4] == mrs_pkg::TYPE_PROGRAM ||
                          byte_i[6:4] == mrs_pkg::TYPE_PRESSURE);
        end
      end else if (stat_vld_q) begin
        if (!dcount_q) begin
          first_d = byte_i[6:0];
          if (two_q) begin
            dcount_d = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else begin
          dcount_d = 1'b0;
          done     = 1'b1;
          d0       = first_q;
          d1       = byte_i[6:0];
        end
      end
    end
  end

  always_comb begin
    evt_valid_o = 1'b0;
    evt_o.kind  = mrs_pkg::KIND_NOTE_OFF;
    evt_o.key   = d0;
    evt_o.value = '0;
    unique case (stat_type_q)
      mrs_pkg::TYPE_NOTE_ON: begin
        evt_valid_o = done;
        if (d1 != '0) begin
          evt_o.kind  = mrs_pkg::KIND_NOTE_ON;
          evt_o.value = d1;
        end
      end
      mrs_pkg::TYPE_NOTE_OFF: begin
        evt_valid_o = done;
      end
      mrs_pkg::TYPE_CONTROL: begin
        evt_valid_o = done;
        if (d0 == mrs_pkg::CC_ALL_SOUND_OFF || d0 == mrs_pkg::CC_ALL_NOTES_OFF) begin
          evt_o.kind = mrs_pkg::KIND_ALL_OFF;
          evt_o.key  = '0;
        end else begin
          evt_o.kind  = mrs_pkg::KIND_CONTROL;
          evt_o.value = d1;
        end
      end
      mrs_pkg::TYPE_PROGRAM: begin
        evt_valid_o = done;
        evt_o.kind  = mrs_pkg::KIND_PROGRAM;
        evt_o.key   = d0 & mrs_pkg::PROGRAM_MASK;
      end
      default: begin
        // Aftertouch, channel pressure and pitch bend only consume their bytes.
        evt_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_vld_q  <= 1'b0;
      stat_type_q <= '0;
      two_q       <= 1'b0;
      dcount_q    <= 1'b0;
      first_q     <= '0;
    end else begin
      stat_vld_q  <= stat_vld_d;
      stat_type_q <= stat_type_d;
      two_q       <= two_d;
      dcount_q    <= dcount_d;
      first_q     <= first_d;
    end
  end

  a_evt_from_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o |-> (adv && !byte_i[7] && stat_vld_q))
    else $error("event raised by a beat that is not a data byte under a status");

  a_common_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && byte_i[7:3] == 5'b11110) |=> (!stat_vld_q && !dcount_q))
    else $error("system-common byte did not clear the running status");

  a_realtime_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && byte_i[7:3] == 5'b11111) |=>
      (stat_vld_q == $past(stat_vld_q) && dcount_q == $past(dcount_q)))
    else $error("real-time byte changed the parser state");

  a_count_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcount_q |-> (stat_vld_q && two_q))
    else $error("pending first data byte without a two-byte status");

  a_all_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid_o && evt_o.kind == mrs_pkg::KIND_ALL_OFF) |->
      (evt_o.key == '0 && evt_o.value == '0))
    else $error("all notes off event carries a nonzero key or value");

endmodule

### rtl/mrs_out_stage.sv
// ----------------------------------------------------------------------------
// MIDI running status parser result register
// Holds one decoded event until the sink takes the beat.
// ----------------------------------------------------------------------------
module mrs_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          evt_valid_i,
  input  mrs_pkg::evt_t evt_i,
  input  logic          byte_valid_i,
  output logic          take_o,
  output logic          out_valid_o,
  output mrs_pkg::evt_t out_evt_o,
  input  logic          out_ready_i
);

  logic          valid_q, valid_d;
  mrs_pkg::evt_t evt_q;
  logic          load;

  assign take_o = !valid_q || out_ready_i;
  assign load   = byte_valid_i && take_o && evt_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      evt_q <= evt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_evt_o   = evt_q;

endmodule

### rtl/midi_running_status_parser.sv
// ----------------------------------------------------------------------------
// MIDI running status parser
// Turns a MIDI byte stream into note, controller and program events.
// ----------------------------------------------------------------------------
// A message's last data byte is held in the input register, then its event in
// the result register. Throughput: one byte per cycle while that register is
// empty or being taken; the input register frees up as it hands off.
// Reset clears the running status, the data count and both valid flags.
// ----------------------------------------------------------------------------
module midi_running_status_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  mrs_byte_if.sink           in_i,
  mrs_event_if.source        out_o
);

  logic          take;
  logic          byte_valid;
  logic [7:0]    byte_s1;
  logic          evt_valid;
  mrs_pkg::evt_t evt;
  mrs_pkg::evt_t out_evt;

  mrs_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_byte_i    (in_i.midi_byte),
    .in_ready_o   (in_i.ready),
    .take_i       (take),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_s1)
  );

  mrs_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_s1),
    .take_i       (take),
    .evt_valid_o  (evt_valid),
    .evt_o        (evt)
  );

  mrs_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_valid_i  (evt_valid),
    .evt_i        (evt),
    .byte_valid_i (byte_valid),
    .take_o       (take),
    .out_valid_o  (out_o.valid),
    .out_evt_o    (out_evt),
    .out_ready_i  (out_o.ready)
  );

  assign out_o.event_kind  = out_evt.kind;
  assign out_o.event_key   = out_evt.key;
  assign out_o.event_value = out_evt.value;

endmodule

### tb/midi_running_status_parser_tb.sv
// ----------------------------------------------------------------------------
// MIDI running status parser testbench
// Drives MIDI byte streams into the parser and checks every emitted event
// against a predictor that tracks running status. Directed messages, random
// message streams, idle gaps on both sides, and an output hold-off are used.
// ----------------------------------------------------------------------------
module midi_running_status_parser_tb;

  // Message types that the package does not name.
  localparam logic [2:0] TYPE_POLY_PRESSURE = 3'h2;  // 0xAn
  localparam logic [2:0] TYPE_PITCH_BEND    = 3'h6;  // 0xEn

  localparam logic [7:0] SYSTEM_FIRST   = 8'hF0;
  localparam logic [7:0] SYSTEM_LAST    = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;
  localparam logic [7:0] REALTIME_LAST  = 8'hFF;

  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;

  logic clk;
  logic rst_n;

  mrs_byte_if  byte_ch ();
  mrs_event_if evt_ch ();

  midi_running_status_parser uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (evt_ch)
  );

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  mrs_pkg::evt_t pending_events[$];

  // Predictor state.
  logic [7:0] parse_status = '0;
  logic [1:0] parse_count = '0;
  logic [1:0] parse_needed = '0;
  logic [6:0] parse_first = '0;

  // Stimulus-side view of the running status, used to build messages.
  logic [7:0] gen_status = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] status_byte(input logic [2:0] mtype, input logic [3:0] chan);
    return {1'b1, mtype, chan};
  endfunction

  // Updates the parse state for one byte and returns 1 when an event follows.
  function automatic bit predict_event(input logic [7:0] b, output mrs_pkg::evt_t ev);
    logic [6:0] d0;
    logic [6:0] d1;
    ev = '{kind: mrs_pkg::KIND_NOTE_ON, key: '0, value: '0};
    if (b[7]) begin
      if (b >= REALTIME_FIRST) return 1'b0;
      if (b[6:4] == mrs_pkg::TYPE_SYSTEM) begin
        parse_status = '0;
        parse_count = '0;
        return 1'b0;
      end
      parse_status = b;
      parse_count = '0;
      parse_needed = (b[6:4] == mrs_pkg::TYPE_PROGRAM ||
                      b[6:4] == mrs_pkg::TYPE_PRESSURE) ? 2'd1 : 2'd2;
      return 1'b0;
    end
    if (parse_status == '0) return 1'b0;
    if (parse_count == '0) begin
      parse_first = b[6:0];
      parse_count = 2'd1;
      if (parse_needed > 2'd1) return 1'b0;
      d0 = b[6:0];
      d1 = '0;
    end else begin
      d0 = parse_first;
      d1 = b[6:0];
    end
    parse_count = '0;
    case (parse_status[6:4])
      mrs_pkg::TYPE_NOTE_ON: begin
        ev.key = d0;
        if (d1 == '0) begin
          ev.kind = mrs_pkg::KIND_NOTE_OFF;
        end else begin
          ev.kind = mrs_pkg::KIND_NOTE_ON;
          ev.value = d1;
        end
      end
      mrs_pkg::TYPE_NOTE_OFF: begin
        ev.kind = mrs_pkg::KIND_NOTE_OFF;
        ev.key = d0;
      end
      mrs_pkg::TYPE_CONTROL: begin
        if (d0 == mrs_pkg::CC_ALL_SOUND_OFF || d0 == mrs_pkg::CC_ALL_NOTES_OFF) begin
          ev.kind = mrs_pkg::KIND_ALL_OFF;
        end else begin
          ev.kind = mrs_pkg::KIND_CONTROL;
          ev.key = d0;
          ev.value = d1;
        end
      end
      mrs_pkg::TYPE_PROGRAM: begin
        ev.kind = mrs_pkg::KIND_PROGRAM;
        ev.key = d0 & mrs_pkg::PROGRAM_MASK;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Checks output beats first, then predicts from the input beat of the same edge.
  always @(posedge clk) begin : event_monitor
    mrs_pkg::evt_t got;
    mrs_pkg::evt_t want;
    if (rst_n) begin
      if (evt_ch.valid && evt_ch.ready) begin
        got = '{kind: mrs_pkg::event_kind_e'(evt_ch.event_kind), key: evt_ch.event_key,
                value: evt_ch.event_value};
        if (pending_events.size() == 0) begin
          note_mismatch($sformatf("event kind %0d key %0d value %0d with none expected",
                                  got.kind, got.key, got.value));
        end else begin
          want = pending_events.pop_front();
          if (got.kind != want.kind)
            note_mismatch($sformatf("event_kind expected %0d, got %0d", want.kind, got.kind));
          if (got.key != want.key)
            note_mismatch($sformatf("event_key expected %0d, got %0d", want.key, got.key));
          if (got.value != want.value)
            note_mismatch($sformatf("event_value expected %0d, got %0d",
                                    want.value, got.value));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        if (predict_event(byte_ch.midi_byte, want)) pending_events.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_ch.valid && byte_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Event receiver: random ready, or a counted hold-off when one is requested.
  initial begin
    evt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        evt_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        evt_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.midi_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic wait_all_events();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_messages();
    logic [7:0] seq[$];
    seq = {8'h00,
           status_byte(mrs_pkg::TYPE_NOTE_ON, 4'h0), 8'h3C, 8'h64, 8'h3C, 8'h00,
           status_byte(mrs_pkg::TYPE_NOTE_OFF, 4'hF), 8'h7F, 8'h7F,
           status_byte(mrs_pkg::TYPE_CONTROL, 4'h5), {1'b0, mrs_pkg::CC_ALL_SOUND_OFF}, 8'h55,
           {1'b0, mrs_pkg::CC_ALL_NOTES_OFF}, 8'h7F, 8'h07, 8'h00,
           status_byte(mrs_pkg::TYPE_PROGRAM, 4'h3), 8'h7F,
           status_byte(mrs_pkg::TYPE_PRESSURE, 4'h0), 8'h10,
           status_byte(TYPE_POLY_PRESSURE, 4'h8), 8'h3C, 8'h40,
           status_byte(TYPE_PITCH_BEND, 4'hF), 8'h00, 8'h7F,
           status_byte(mrs_pkg::TYPE_NOTE_ON, 4'h9), 8'h30, REALTIME_FIRST, 8'h50,
           REALTIME_LAST,
           SYSTEM_FIRST, 8'h11,
           status_byte(mrs_pkg::TYPE_NOTE_ON, 4'h1), 8'h05,
           status_byte(mrs_pkg::TYPE_CONTROL, 4'h2),
           8'h06, SYSTEM_LAST, 8'h07};
    send_seq(seq);
    wait_all_events();
  endtask

  // Builds and sends one message, a broken one, or a stray byte.
  // Returns the number of bytes sent that are not real-time bytes.
  task automatic send_random_message(output int counted);
    logic [7:0] seq[$];
    logic [7:0] b;
    logic [2:0] mtype;
    int r;
    int n_data;
    r = $urandom_range(99);
    counted = 0;
    if (r < 8) begin
      b = 8'($urandom_range(255));
      if (b[7] && b < REALTIME_FIRST) gen_status = (b >= SYSTEM_FIRST) ? 8'h00 : b;
      seq.push_back(b);
      counted = (b < REALTIME_FIRST) ? 1 : 0;
    end else if (r < 12) begin
      seq.push_back(REALTIME_FIRST + 8'($urandom_range(7)));
    end else if (r < 16) begin
      seq.push_back(SYSTEM_FIRST + 8'($urandom_range(7)));
      gen_status = '0;
      counted = 1;
    end else begin
      if (gen_status == '0 || $urandom_range(99) < 65) begin
        case ($urandom_range(9))
          0, 1, 2: mtype = mrs_pkg::TYPE_NOTE_ON;
          3:       mtype = mrs_pkg::TYPE_NOTE_OFF;
          4, 5:    mtype = mrs_pkg::TYPE_CONTROL;
          6:       mtype = mrs_pkg::TYPE_PROGRAM;
          7:       mtype = mrs_pkg::TYPE_PRESSURE;
          8:       mtype = TYPE_POLY_PRESSURE;
          default: mtype = TYPE_PITCH_BEND;
        endcase
        gen_status = status_byte(mtype, 4'($urandom_range(15)));
        seq.push_back(gen_status);
      end
      mtype = gen_status[6:4];
      n_data = (mtype == mrs_pkg::TYPE_PROGRAM || mtype == mrs_pkg::TYPE_PRESSURE) ? 1 : 2;
      // A few messages are cut short so the next one lands mid-message.
      if (r < 21 && n_data == 2) n_data = 1;
      for (int i = 0; i < n_data; i++) begin
        b = 8'($urandom_range(127));
        if (i == 0 && mtype == mrs_pkg::TYPE_CONTROL && $urandom_range(4) == 0)
          b = {1'b0, $urandom_range(1) ? mrs_pkg::CC_ALL_SOUND_OFF : mrs_pkg::CC_ALL_NOTES_OFF};
        if (i == 1 && mtype == mrs_pkg::TYPE_NOTE_ON && $urandom_range(4) == 0) b = 8'h00;
        seq.push_back(b);
        if ($urandom_range(9) == 0) seq.push_back(REALTIME_FIRST + 8'($urandom_range(7)));
      end
      foreach (seq[i]) if (seq[i] < REALTIME_FIRST) counted++;
    end
    send_seq(seq);
  endtask

  task automatic test_random_stream(input int n_items);
    int sent;
    int counted;
    sent = 0;
    while (sent < n_items) begin
      send_random_message(counted);
      sent += counted;
    end
    wait_all_events();
  endtask

  // Holds the event side off while note messages keep coming, so the parser
  // backs up and stalls its byte input.
  task automatic test_output_backpressure();
    logic [7:0] seq[$];
    send_byte(status_byte(mrs_pkg::TYPE_NOTE_ON, 4'h7));
    gen_status = status_byte(mrs_pkg::TYPE_NOTE_ON, 4'h7);
    hold_cycles = 60;
    repeat (24) begin
      seq = {8'($urandom_range(127)), 8'($urandom_range(1, 127))};
      send_seq(seq);
    end
    wait_all_events();
  endtask

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.midi_byte = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 65;
    test_directed_messages();
    test_random_stream(100);

    send_idle_pct = 65;
    recv_idle_pct = 21;
    test_random_stream(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_stream(100);

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mrs_pkg.sv
rtl/mrs_if.sv
rtl/mrs_in_stage.sv
rtl/mrs_decode.sv
rtl/mrs_out_stage.sv
rtl/midi_running_status_parser.sv
tb/midi_running_status_parser_tb.sv
